// ===== rtl/core/sfc_pkg.sv =====
package sfc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int ENV_W    = 24;
  localparam int COEF_W   = 25;
  localparam int CFG_W    = 25;
  localparam int CFG_IDX_W = 3;

  localparam logic [24:0] Q24_ONE    = 25'd16777216;
  localparam logic [16:0] Q16_ONE    = 17'd65536;
  localparam logic [23:0] FAST_LEVEL = 24'd52428;
  localparam logic [23:0] OUT_LIMIT  = 24'd5242880;
  localparam logic [23:0] CLIP_LEVEL = 24'd5190452;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_LIMITER   = 3'd1,
    REG_MAKEUP    = 3'd2,
    REG_WET       = 3'd3,
    REG_ATTACK    = 3'd4,
    REG_REL_FAST  = 3'd5,
    REG_REL_SLOW  = 3'd6,
    REG_BYPASS    = 3'd7
  } reg_idx_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [43:0] num;
    logic [27:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [24:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/core/sfc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module sfc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sfc_pkg::div_req_t req,
  output sfc_pkg::div_rsp_t rsp
);

  logic [43:0] num_r, num_nxt;
  logic [27:0] den_r, den_nxt;
  logic [28:0] rem_r, rem_nxt;
  logic [43:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [29:0] trial;
  logic [28:0] shifted;

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[27:0], num_r[43]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    if (req.start) begin
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = 6'd44;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[42:0], 1'b0};
      if (!trial[29]) begin
        rem_nxt = trial[28:0];
        quo_nxt = {quo_r[42:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[42:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r[24:0];

endmodule

// ===== rtl/core/stereo_feedforward_compressor.sv =====
// Path from input accept to out_tvalid: ENV_MUL1, ENV_MUL2, ENV_DONE, the serial gain divider
// (only when the envelope is above the threshold), G, K, OUT_L, OUT_R, EMIT; bypass goes to EMIT.
// One word at a time; in_tready is high only in idle, so no word is taken until the last has left EMIT.
// Throughput is set by the one-bit-per-cycle gain divider, the shared multiplier and out_tready.
// A finished word sits in the output register while the next one is accepted.
// Reset (synchronous, rst_n low) loads the register defaults; all envelopes then read as zero.
module stereo_feedforward_compressor #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // channel[3:0], left_sample[27:4], right_sample[51:28]
  input  logic        in_tuser,   // right_present
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // channel_out[3:0], left_out[27:4], right_out[51:28]
  output logic        out_tuser,  // clip
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [24:0] cfg_wdata
);

  // a 4-bit channel reaches at most 16 slots
  localparam int SLOTS  = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ENV_MUL1, S_ENV_MUL2, S_ENV_DONE, S_DIV_START, S_DIV_WAIT,
    S_G, S_K, S_OUT_L, S_OUT_R, S_EMIT
  } state_t;

  logic [19:0] thr_r;
  logic        lim_r;
  logic [22:0] mk_r;
  logic [16:0] wet_r;
  logic [24:0] att_r, relf_r, rels_r;
  logic        byp_r;

  logic [sfc_pkg::ENV_W-1:0] env_mem [SLOTS];
  logic [SLOTS-1:0] env_vld_r;

  state_t      st_r;
  logic [3:0]  ch_r;
  logic [SLOT_W-1:0] slot_r;
  logic signed [23:0] l_r, r_r;
  logic [23:0] env_r, rect_r, ol_r, or_r;
  logic [24:0] c_r;
  logic        att_sel_r;
  logic [49:0] acc_r;
  logic [24:0] gr_r;
  logic [22:0] g_r;
  logic [39:0] k_r;
  logic        ov_r;
  logic [55:0] odata_r;
  logic        oclip_r, ovalid_r;

  sfc_pkg::div_req_t dreq;
  sfc_pkg::div_rsp_t drsp;

  sfc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // shared multiplier operands (up to 40x25)
  logic [39:0] ma;
  logic [24:0] mb;
  logic [64:0] mp;
  assign mp = ma * mb;

  logic [3:0]  in_ch;
  logic signed [23:0] in_l, in_r;
  logic signed [24:0] sum;
  logic [24:0] sum_abs;
  logic [23:0] rect;
  logic [SLOT_W-1:0] in_slot;
  logic [23:0] mag_l, mag_r, cur_mag;
  logic [26:0] over;
  logic [27:0] den;
  logic [33:0] wet_c;
  logic [16:0] wet_eff;
  logic [49:0] env_new_acc;
  logic [23:0] env_new;
  logic [64:0] rnd;
  logic [32:0] p;
  logic [23:0] p_sat;
  logic signed [23:0] signed_out_l, signed_out_r;

  // fold the channel onto the envelope slots; the table is built at elaboration
  function automatic logic [SLOT_W-1:0] slot_of(input logic [3:0] ch);
    logic [SLOT_W-1:0] s;
    s = '0;
    for (int i = 0; i < 16; i++) begin
      if (ch == 4'(i)) s = SLOT_W'(i % CHANNELS);
    end
    return s;
  endfunction

  function automatic logic [24:0] clamp1(input logic [24:0] c);
    return (c > sfc_pkg::Q24_ONE) ? sfc_pkg::Q24_ONE : c;
  endfunction

  assign in_ch   = in_tdata[3:0];
  assign in_l    = in_tdata[27:4];
  assign in_r    = in_tuser ? in_tdata[51:28] : in_tdata[27:4];
  assign in_slot = slot_of(in_ch);
  assign sum     = 25'(l_r) + 25'(r_r);
  assign sum_abs = sum[24] ? -sum : sum;
  assign rect    = sum_abs[24:1];
  assign mag_l   = l_r[23] ? -l_r : l_r;
  assign mag_r   = r_r[23] ? -r_r : r_r;
  assign cur_mag = (st_r == S_OUT_L) ? mag_l : mag_r;
  assign wet_eff = (wet_r > sfc_pkg::Q16_ONE) ? sfc_pkg::Q16_ONE : wet_r;
  assign over    = 27'(env_r) - 27'(thr_r);
  assign den     = 28'd524288 + (lim_r ? (28'(over) * 28'd9) : {over, 1'b0});
  assign wet_c   = 34'(sfc_pkg::Q16_ONE - wet_eff) << 16;

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      S_ENV_MUL2: begin ma = 40'(env_r); mb = c_r; end
      S_ENV_DONE: begin ma = 40'(rect_r); mb = sfc_pkg::Q24_ONE - c_r; end
      S_G:        begin ma = 40'(gr_r); mb = 25'(mk_r); end
      S_K:        begin ma = 40'(g_r); mb = 25'(wet_eff); end
      S_OUT_L, S_OUT_R: begin ma = k_r; mb = 25'(cur_mag); end
      default:    begin ma = '0; mb = '0; end
    endcase
  end

  assign env_new_acc = acc_r + 50'(mp);
  assign env_new = att_sel_r ? 24'((env_new_acc + 50'(24'hFFFFFF)) >> 24)
                             : env_new_acc[47:24];
  assign rnd   = mp + 65'h80000000;
  assign p     = rnd[64:32];
  assign p_sat = (p > 33'(sfc_pkg::OUT_LIMIT)) ? sfc_pkg::OUT_LIMIT : p[23:0];

  assign signed_out_l = l_r[23] ? -ol_r : ol_r;
  assign signed_out_r = r_r[23] ? -p_sat : p_sat;

  assign dreq.start = (st_r == S_DIV_START);
  assign dreq.num   = 44'h800_0000_0000 + 44'(den >> 1);
  assign dreq.den   = den;

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = oclip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 20'd262144;
      lim_r  <= 1'b0;
      mk_r   <= 23'd207243;
      wet_r  <= 17'd65536;
      att_r  <= 25'd16742276;
      relf_r <= 25'd16771391;
      rels_r <= 25'd16776983;
      byp_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        sfc_pkg::REG_THRESHOLD: thr_r  <= cfg_wdata[19:0];
        sfc_pkg::REG_LIMITER:   lim_r  <= cfg_wdata[0];
        sfc_pkg::REG_MAKEUP:    mk_r   <= cfg_wdata[22:0];
        sfc_pkg::REG_WET:       wet_r  <= cfg_wdata[16:0];
        sfc_pkg::REG_ATTACK:    att_r  <= cfg_wdata;
        sfc_pkg::REG_REL_FAST:  relf_r <= cfg_wdata;
        sfc_pkg::REG_REL_SLOW:  rels_r <= cfg_wdata;
        default:                byp_r  <= cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_ENV_DONE) env_mem[slot_r] <= env_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      ovalid_r  <= 1'b0;
      env_vld_r <= '0;
    end else begin
      if (st_r == S_EMIT && (!ovalid_r || out_tready)) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            ch_r   <= in_ch;
            slot_r <= in_slot;
            l_r    <= in_l;
            r_r    <= in_r;
            env_r  <= env_vld_r[in_slot] ? env_mem[in_slot] : '0;
            st_r   <= byp_r ? S_EMIT : S_ENV_MUL1;
            ov_r   <= byp_r;
          end
        end
        S_ENV_MUL1: begin
          // choose coefficient from rectified input and stored envelope
          rect_r <= rect;
          if (rect > env_r) begin
            c_r <= clamp1(att_r); att_sel_r <= 1'b1;
          end else if (env_r > sfc_pkg::FAST_LEVEL) begin
            c_r <= clamp1(relf_r); att_sel_r <= 1'b0;
          end else begin
            c_r <= clamp1(rels_r); att_sel_r <= 1'b0;
          end
          st_r <= S_ENV_MUL2;
        end
        S_ENV_MUL2: begin
          acc_r <= 50'(mp);
          st_r  <= S_ENV_DONE;
        end
        S_ENV_DONE: begin
          env_r <= env_new;
          env_vld_r[slot_r] <= 1'b1;
          st_r <= S_DIV_START;
        end
        S_DIV_START: begin
          if (env_r > 24'(thr_r)) begin
            st_r <= S_DIV_WAIT;
          end else begin
            gr_r <= sfc_pkg::Q24_ONE;
            st_r <= S_G;
          end
        end
        S_DIV_WAIT: begin
          if (drsp.done) begin
            gr_r <= drsp.quo;
            st_r <= S_G;
          end
        end
        S_G: begin
          g_r  <= 23'((mp + 65'h800000) >> 24);
          st_r <= S_K;
        end
        S_K: begin
          k_r  <= 40'(mp) + 40'(wet_c);
          st_r <= S_OUT_L;
        end
        S_OUT_L: begin
          ol_r <= p_sat;
          st_r <= S_OUT_R;
        end
        S_OUT_R: begin
          or_r <= p_sat;
          l_r  <= signed_out_l;
          r_r  <= signed_out_r;
          st_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!ovalid_r || out_tready) begin
            odata_r  <= {4'd0, r_r, l_r, ch_r};
            oclip_r  <= !ov_r && ((ol_r >= sfc_pkg::CLIP_LEVEL) ||
                                  (or_r >= sfc_pkg::CLIP_LEVEL));
            st_r     <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
